[rtl/atrlp_pkg.sv]
// Shared types, character constants and line parsing functions of the AT response line parser.
package atrlp_pkg;

	localparam int MAX_RES = 8;
	localparam int NUM_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);

	localparam logic [7:0]  CH_TAB      = 8'h09;
	localparam logic [7:0]  CH_LF       = 8'h0A;
	localparam logic [7:0]  CH_CR       = 8'h0D;
	localparam logic [7:0]  CH_SPACE    = 8'h20;
	localparam logic [7:0]  CH_QUOTE    = 8'h22;
	localparam logic [7:0]  CH_HASH     = 8'h23;
	localparam logic [7:0]  CH_EQ       = 8'h3D;
	localparam logic [7:0]  CH_UA       = 8'h41;
	localparam logic [7:0]  CH_UT       = 8'h54;
	localparam logic [7:0]  CH_BS       = 8'h5C;
	localparam logic [7:0]  CH_LA       = 8'h61;
	localparam logic [7:0]  CH_LN       = 8'h6E;
	localparam logic [7:0]  CH_LR       = 8'h72;
	localparam logic [7:0]  CH_LT       = 8'h74;
	localparam logic [7:0]  CH_LZ       = 8'h7A;
	localparam logic [7:0]  CASE_OFFSET = 8'h20;
	localparam logic [15:0] CRLF        = 16'h0D0A;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_ONE   = 3'd1,
		PH_REQ   = 3'd2,
		PH_ANS   = 3'd3,
		PH_SKIP  = 3'd4,
		PH_BAD   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_REQ  = 2'd0,
		KIND_ANS  = 2'd1,
		KIND_STAT = 2'd2
	} kind_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  first_char;
		logic        quote_open;
		logic [1:0]  marker_progress;
		logic        held_bs;
		logic [7:0]  hold_byte;
		logic [1:0]  hold_cnt;
		logic [15:0] last_two;
		logic        answer_seen;
	} line_state_t;

	localparam line_state_t LINE_RESET = '{phase: PH_START, default: '0};

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       ok;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] items;
		logic [NUM_W-1:0]   n;
	} batch_t;

	typedef struct packed {
		line_state_t st;
		batch_t      b;
		logic        bad;
	} work_t;

	// Handoff from the parse stage to the result buffer.
	typedef struct packed {
		logic        valid;
		batch_t      b;
		logic [15:0] count;
	} push_t;

	function automatic work_t put(input work_t w, input kind_t k, input logic [7:0] d,
		input logic ok);
		work_t r;
		r = w;
		if (r.b.n < NUM_W'(MAX_RES)) begin
			r.b.items[r.b.n[IDX_W-1:0]] = '{kind: k, data: d, ok: ok};
			r.b.n = r.b.n + NUM_W'(1);
		end
		return r;
	endfunction

	function automatic work_t request_out(input work_t w, input logic [7:0] c);
		work_t r;
		logic [7:0] ch;
		r = w;
		ch = c;
		if (ch == CH_QUOTE)
			r.st.quote_open = ~r.st.quote_open;
		if (!((ch == CH_SPACE || ch == CH_TAB) && !r.st.quote_open)) begin
			if (!r.st.quote_open && ch >= CH_LA && ch <= CH_LZ)
				ch = ch - CASE_OFFSET;
			r = put(r, KIND_REQ, ch, 1'b0);
		end
		return r;
	endfunction

	function automatic work_t answer_put(input work_t w, input logic [7:0] d);
		work_t r;
		r = put(w, KIND_ANS, d, 1'b0);
		r.st.last_two = {r.st.last_two[7:0], d};
		return r;
	endfunction

	// Adds the leading CR LF unless the answer itself opens with one.
	function automatic work_t frame_in(input work_t w, input logic [7:0] d);
		work_t r;
		r = w;
		case (r.st.hold_cnt)
			2'd0: begin
				if (d == CH_CR) begin
					r.st.hold_byte = d;
					r.st.hold_cnt = 2'd1;
				end else begin
					r = answer_put(r, CH_CR);
					r = answer_put(r, CH_LF);
					r = answer_put(r, d);
					r.st.hold_cnt = 2'd2;
				end
			end
			2'd1: begin
				r = answer_put(r, CH_CR);
				r = answer_put(r, CH_LF);
				if (d != CH_LF) begin
					r = answer_put(r, r.st.hold_byte);
					r = answer_put(r, d);
				end
				r.st.hold_cnt = 2'd2;
			end
			default: begin
				r = answer_put(r, d);
			end
		endcase
		return r;
	endfunction

	function automatic work_t decode_in(input work_t w, input logic [7:0] c);
		work_t r;
		r = w;
		r.st.answer_seen = 1'b1;
		if (r.st.held_bs) begin
			r.st.held_bs = 1'b0;
			case (c)
				CH_LR:    r = frame_in(r, CH_CR);
				CH_LN:    r = frame_in(r, CH_LF);
				CH_LT:    r = frame_in(r, CH_TAB);
				CH_QUOTE: r = frame_in(r, CH_QUOTE);
				CH_BS:    r = frame_in(r, CH_BS);
				default: begin
					r = frame_in(r, CH_BS);
					r = frame_in(r, c);
				end
			endcase
		end else if (c == CH_BS) begin
			r.st.held_bs = 1'b1;
		end else begin
			r = frame_in(r, c);
		end
		return r;
	endfunction

	// Looks for the backslash, r, equals marker; partial matches are replayed as text.
	function automatic work_t request_in(input work_t w, input logic [7:0] c);
		work_t r;
		r = w;
		if (r.st.marker_progress == 2'd2 && c == CH_EQ) begin
			r.st.marker_progress = 2'd0;
			r.st.phase = PH_ANS;
			r.st.answer_seen = 1'b0;
			r.st.held_bs = 1'b0;
			r.st.hold_cnt = 2'd0;
			r.st.hold_byte = '0;
			r.st.last_two = '0;
		end else if (r.st.marker_progress == 2'd1 && c == CH_LR) begin
			r.st.marker_progress = 2'd2;
		end else begin
			if (r.st.marker_progress != 2'd0)
				r = request_out(r, CH_BS);
			if (r.st.marker_progress == 2'd2)
				r = request_out(r, CH_LR);
			r.st.marker_progress = 2'd0;
			if (c == CH_BS)
				r.st.marker_progress = 2'd1;
			else
				r = request_out(r, c);
		end
		return r;
	endfunction

	function automatic work_t content_in(input work_t w, input logic [7:0] c);
		work_t r;
		r = w;
		unique case (r.st.phase)
			PH_START: begin
				if (c == CH_HASH) begin
					r.st.phase = PH_SKIP;
				end else begin
					r.st.first_char = c;
					r.st.phase = PH_ONE;
				end
			end
			PH_ONE: begin
				if ((r.st.first_char == CH_UA && c == CH_UT) ||
				    (r.st.first_char == CH_LA && c == CH_LT)) begin
					r = request_out(r, r.st.first_char);
					r = request_out(r, c);
					r.st.phase = PH_REQ;
				end else begin
					r.st.phase = PH_BAD;
				end
			end
			PH_REQ:  r = request_in(r, c);
			PH_ANS:  r = decode_in(r, c);
			default: r = w;
		endcase
		return r;
	endfunction

	function automatic work_t end_line(input work_t w);
		work_t r;
		r = w;
		if (r.st.phase == PH_START || r.st.phase == PH_SKIP) begin
			r = w;
		end else if (r.st.phase == PH_ANS && r.st.answer_seen) begin
			if (r.st.held_bs) begin
				r.st.held_bs = 1'b0;
				r = frame_in(r, CH_BS);
			end
			if (r.st.hold_cnt == 2'd1) begin
				r = answer_put(r, CH_CR);
				r = answer_put(r, CH_LF);
				r = answer_put(r, r.st.hold_byte);
				r.st.hold_cnt = 2'd2;
			end
			if (r.st.last_two != CRLF) begin
				r = answer_put(r, CH_CR);
				r = answer_put(r, CH_LF);
			end
			r = put(r, KIND_STAT, 8'h00, 1'b1);
		end else begin
			r.bad = 1'b1;
			r = put(r, KIND_STAT, 8'h00, 1'b0);
		end
		r.st = LINE_RESET;
		return r;
	endfunction

endpackage

[rtl/atrlp_in_if.sv]
// Input byte channel of the AT response line parser.
interface atrlp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

[rtl/atrlp_out_if.sv]
// Result channel of the AT response line parser.
interface atrlp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic        line_ok;
	logic [15:0] bad_line_count;
	logic        last;

	modport source (output valid, output kind, output out_byte, output line_ok,
		output bad_line_count, output last, input ready);
	modport sink (input valid, input kind, input out_byte, input line_ok,
		input bad_line_count, input last, output ready);
endinterface

[rtl/atrlp_core.sv]
// Input register, line state and single-pass parse of one byte into a batch of results.
module atrlp_core import atrlp_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	atrlp_in_if.sink   in_ch,
	input  logic       push_ready,
	output push_t      push
);

	logic                  valid_s1;
	logic [7:0]            data_s1;
	line_state_t           line_q;
	logic                  held_cr_q;
	logic [COUNT_BITS-1:0] bad_q;

	work_t                 w;
	logic                  held_cr_d;
	logic [COUNT_BITS-1:0] count_d;
	logic                  advance;

	always_comb begin
		w = '0;
		w.st = line_q;
		held_cr_d = 1'b0;
		// A held CR is dropped when LF follows; otherwise it counts as line text.
		if (held_cr_q && data_s1 == CH_LF) begin
			w = end_line(w);
		end else begin
			if (held_cr_q)
				w = content_in(w, CH_CR);
			if (data_s1 == CH_LF)
				w = end_line(w);
			else if (data_s1 == CH_CR)
				held_cr_d = 1'b1;
			else
				w = content_in(w, data_s1);
		end

		count_d = bad_q;
		if (w.bad && bad_q != '1)
			count_d = bad_q + COUNT_BITS'(1);
	end

	// A byte without results needs no room in the result buffer.
	assign advance     = valid_s1 && (w.b.n == '0 || push_ready);
	assign in_ch.ready = !valid_s1 || advance;

	assign push.valid = advance && w.b.n != '0;
	assign push.b     = w.b;
	assign push.count = 16'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			line_q    <= LINE_RESET;
			held_cr_q <= 1'b0;
			bad_q     <= '0;
		end else begin
			if (in_ch.ready)
				valid_s1 <= in_ch.valid;
			if (advance) begin
				line_q    <= w.st;
				held_cr_q <= held_cr_d;
				bad_q     <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid)
			data_s1 <= in_ch.data_byte;
	end

endmodule

[rtl/atrlp_outq.sv]
// Result buffer that holds one batch and hands its results out one per transfer.
module atrlp_outq import atrlp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  push_t        push,
	output logic         push_ready,
	atrlp_out_if.source  out_ch
);

	batch_t           batch_q;
	logic [15:0]      cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic             full_q;

	res_t cur;
	logic is_last;
	logic fire;

	assign cur     = batch_q.items[idx_q];
	assign is_last = ({1'b0, idx_q} + NUM_W'(1)) == batch_q.n;
	assign fire    = full_q && out_ch.ready;

	// A new batch may land in the same cycle as the final transfer of the old one.
	assign push_ready = !full_q || (fire && is_last);

	assign out_ch.valid          = full_q;
	assign out_ch.kind           = cur.kind;
	assign out_ch.out_byte       = cur.data;
	assign out_ch.line_ok        = cur.ok;
	assign out_ch.bad_line_count = cnt_q;
	assign out_ch.last           = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (push.valid) begin
				full_q <= 1'b1;
				idx_q  <= '0;
			end else if (fire) begin
				if (is_last)
					full_q <= 1'b0;
				else
					idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			batch_q <= push.b;
			cnt_q   <= push.count;
		end
	end

	a_batch_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (batch_q.n != '0 && batch_q.n <= NUM_W'(MAX_RES)))
		else $error("result buffer holds an empty or oversized batch");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> ({1'b0, idx_q} < batch_q.n))
		else $error("result index beyond batch size");

	a_push_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> push_ready)
		else $error("batch pushed while buffer busy");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !is_last) |=> (full_q && idx_q == IDX_W'($past(idx_q) + 1'b1)))
		else $error("result index did not advance after transfer");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && cur.kind == KIND_STAT) |-> is_last)
		else $error("status result is not the last of its batch");

endmodule

[rtl/at_response_line_parser_unit.sv]
// Top level of the AT response line parser: parse stage followed by the result buffer.
//
// Usage: raw bytes of a response table text enter on in_ch, one byte per transfer.
// Results leave on out_ch: request bytes (kind 0), decoded and framed answer bytes
// (kind 1) and one status item (kind 2) per line that is not empty or a comment.
// The consumer drops the bytes of a line whose status carries line_ok low.
// last marks the final result caused by one input byte; bad_line_count is the
// saturating count of rejected lines, COUNT_BITS wide inside, low 16 bits shown.
// A byte is registered at its transfer and parsed in the following cycle; its results
// are then registered in the result buffer, which offers them on out_ch.
// Throughput: one input byte per cycle while each byte yields at most one result and
// the receiver is ready. A byte yielding n results (up to 8) hands them out one per
// transfer on the single output port; bytes yielding none pass without touching the
// output.
// Reset clears the line state, the held CR, the counter and any pending results.
// When the receiver stalls, the result buffer holds its batch; the parse stage
// keeps taking bytes that yield no results, holds the first byte that yields
// any, and in_ch.ready drops until the buffer takes that batch.
module at_response_line_parser_unit import atrlp_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	atrlp_in_if.sink     in_ch,
	atrlp_out_if.source  out_ch
);

	push_t push;
	logic  push_ready;

	atrlp_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_ready (push_ready),
		.push       (push)
	);

	atrlp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.out_ch     (out_ch)
	);

endmodule

[dv/atrlp_checker.sv]
// Result checker of the AT response line parser: predicts every result and compares it.
module atrlp_checker import atrlp_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	atrlp_in_if   in_ch,
	atrlp_out_if  out_ch,
	output int    errors,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned REJECT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

	typedef enum logic [1:0] {
		MK_NONE = 2'd0,
		MK_BS   = 2'd1,
		MK_BS_R = 2'd2
	} marker_t;

	typedef enum logic [1:0] {
		FR_NONE    = 2'd0,
		FR_CR_HELD = 2'd1,
		FR_DONE    = 2'd2
	} frame_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        ok;
		logic [15:0] count;
		logic        last;
	} parse_result_t;

	parse_result_t awaited[$];
	parse_result_t byte_results[$];
	parse_result_t want;

	phase_t          ph;
	logic [7:0]      lead_char;
	logic            in_quote;
	marker_t         marker_seen;
	logic            cr_pending;
	logic            esc_pending;
	logic [7:0]      held_cr;
	frame_t          frame_state;
	logic [15:0]     answer_tail;
	logic            answer_any;
	longint unsigned rejects;

	task automatic put_result(input kind_t k, input logic [7:0] d, input logic ok);
		parse_result_t r;
		if (byte_results.size() < MAX_RES) begin
			r.kind = k;
			r.data = d;
			r.ok = ok;
			r.count = rejects[15:0];
			r.last = 1'b0;
			byte_results = {byte_results, r};
		end
	endtask

	task automatic emit_request(input logic [7:0] c);
		logic [7:0] ch;
		ch = c;
		if (ch == CH_QUOTE)
			in_quote = ~in_quote;
		if ((ch == CH_SPACE || ch == CH_TAB) && !in_quote)
			return;
		if (!in_quote && ch >= CH_LA && ch <= CH_LZ)
			ch = ch - CASE_OFFSET;
		put_result(KIND_REQ, ch, 1'b0);
	endtask

	task automatic emit_answer(input logic [7:0] d);
		put_result(KIND_ANS, d, 1'b0);
		answer_tail = {answer_tail[7:0], d};
	endtask

	// A leading CR is held back until the next byte shows whether the answer opens with CR LF.
	task automatic frame_answer(input logic [7:0] d);
		case (frame_state)
			FR_NONE: begin
				if (d == CH_CR) begin
					held_cr = d;
					frame_state = FR_CR_HELD;
				end else begin
					emit_answer(CH_CR);
					emit_answer(CH_LF);
					emit_answer(d);
					frame_state = FR_DONE;
				end
			end
			FR_CR_HELD: begin
				emit_answer(CH_CR);
				emit_answer(CH_LF);
				if (d != CH_LF) begin
					emit_answer(held_cr);
					emit_answer(d);
				end
				frame_state = FR_DONE;
			end
			default: begin
				emit_answer(d);
			end
		endcase
	endtask

	task automatic decode_answer(input logic [7:0] c);
		answer_any = 1'b1;
		if (esc_pending) begin
			esc_pending = 1'b0;
			case (c)
				CH_LR:    frame_answer(CH_CR);
				CH_LN:    frame_answer(CH_LF);
				CH_LT:    frame_answer(CH_TAB);
				CH_QUOTE: frame_answer(CH_QUOTE);
				CH_BS:    frame_answer(CH_BS);
				default: begin
					frame_answer(CH_BS);
					frame_answer(c);
				end
			endcase
		end else if (c == CH_BS) begin
			esc_pending = 1'b1;
		end else begin
			frame_answer(c);
		end
	endtask

	// A partial marker that breaks off is replayed as ordinary request text.
	task automatic scan_request(input logic [7:0] c);
		if (marker_seen == MK_BS_R && c == CH_EQ) begin
			marker_seen = MK_NONE;
			ph = PH_ANS;
			answer_any = 1'b0;
			esc_pending = 1'b0;
			frame_state = FR_NONE;
			held_cr = '0;
			answer_tail = '0;
		end else if (marker_seen == MK_BS && c == CH_LR) begin
			marker_seen = MK_BS_R;
		end else begin
			if (marker_seen != MK_NONE)
				emit_request(CH_BS);
			if (marker_seen == MK_BS_R)
				emit_request(CH_LR);
			marker_seen = MK_NONE;
			if (c == CH_BS)
				marker_seen = MK_BS;
			else
				emit_request(c);
		end
	endtask

	task automatic line_byte(input logic [7:0] c);
		case (ph)
			PH_START: begin
				if (c == CH_HASH) begin
					ph = PH_SKIP;
				end else begin
					lead_char = c;
					ph = PH_ONE;
				end
			end
			PH_ONE: begin
				if ((lead_char == CH_UA && c == CH_UT) ||
				    (lead_char == CH_LA && c == CH_LT)) begin
					emit_request(lead_char);
					emit_request(c);
					ph = PH_REQ;
				end else begin
					ph = PH_BAD;
				end
			end
			PH_REQ:  scan_request(c);
			PH_ANS:  decode_answer(c);
			default: ;
		endcase
	endtask

	task automatic new_line();
		ph = PH_START;
		lead_char = '0;
		in_quote = 1'b0;
		marker_seen = MK_NONE;
		esc_pending = 1'b0;
		held_cr = '0;
		frame_state = FR_NONE;
		answer_tail = '0;
		answer_any = 1'b0;
	endtask

	task automatic close_line();
		if (!(ph == PH_START || ph == PH_SKIP)) begin
			if (ph == PH_ANS && answer_any) begin
				if (esc_pending) begin
					esc_pending = 1'b0;
					frame_answer(CH_BS);
				end
				if (frame_state == FR_CR_HELD) begin
					emit_answer(CH_CR);
					emit_answer(CH_LF);
					emit_answer(held_cr);
					frame_state = FR_DONE;
				end
				if (answer_tail != CRLF) begin
					emit_answer(CH_CR);
					emit_answer(CH_LF);
				end
				put_result(KIND_STAT, 8'h00, 1'b1);
			end else begin
				if (rejects < REJECT_MAX)
					rejects++;
				put_result(KIND_STAT, 8'h00, 1'b0);
			end
		end
		new_line();
	endtask

	task automatic predict_byte(input logic [7:0] b);
		byte_results.delete();
		if (cr_pending && b == CH_LF) begin
			cr_pending = 1'b0;
			close_line();
		end else begin
			// A CR not followed by LF counts as an ordinary line byte.
			if (cr_pending) begin
				cr_pending = 1'b0;
				line_byte(CH_CR);
			end
			if (b == CH_LF)
				close_line();
			else if (b == CH_CR)
				cr_pending = 1'b1;
			else
				line_byte(b);
		end
		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
		awaited = {awaited, byte_results};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_line();
			cr_pending = 1'b0;
			rejects = 0;
			awaited.delete();
			byte_results.delete();
			errors = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (awaited.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: kind %0d byte %h ok %b count %0d last %b",
						$realtime, out_ch.kind, out_ch.out_byte, out_ch.line_ok,
						out_ch.bad_line_count, out_ch.last);
				end else begin
					want = awaited.pop_front();
					if (want.kind !== out_ch.kind || want.data !== out_ch.out_byte ||
					    want.ok !== out_ch.line_ok || want.count !== out_ch.bad_line_count ||
					    want.last !== out_ch.last) begin
						errors++;
						$display("%0t: expected kind %0d byte %h ok %b count %0d last %b",
							$realtime, want.kind, want.data, want.ok, want.count, want.last);
						$display("%0t: actual   kind %0d byte %h ok %b count %0d last %b",
							$realtime, out_ch.kind, out_ch.out_byte, out_ch.line_ok,
							out_ch.bad_line_count, out_ch.last);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_byte(in_ch.data_byte);
		end
		pending = awaited.size();
	end

endmodule

[dv/tb_at_response_line_parser_unit.sv]
// Testbench top of the AT response line parser: clock, reset, byte stimulus and verdict.
module tb_at_response_line_parser_unit import atrlp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CNT_W       = 4;     // small counter so that saturation is reached
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 76;

	typedef logic [7:0] octet_q_t[$];

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   open_results;
	int   send_idle;
	int   sink_stall;
	bit   long_hold;
	int   quiet;

	atrlp_in_if  in_ch();
	atrlp_out_if out_ch();

	at_response_line_parser_unit #(.COUNT_BITS(CNT_W)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	atrlp_checker #(.COUNT_BITS(CNT_W)) u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.errors  (fail_count),
		.pending (open_results)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Any byte but LF, so that random text does not end the line early.
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] request_char();
		case ($urandom_range(7))
			0:       return CH_LA + 8'($urandom_range(25));
			1:       return CH_UA + 8'($urandom_range(25));
			2:       return CH_SPACE;
			3:       return CH_TAB;
			4:       return CH_QUOTE;
			5:       return CH_BS;
			6:       return CH_LR;
			default: return text_byte();
		endcase
	endfunction

	task automatic append_byte(ref octet_q_t q, input logic [7:0] b);
		q = {q, b};
	endtask

	task automatic add_text(ref octet_q_t q, input string s);
		for (int i = 0; i < s.len(); i++)
			append_byte(q, s[i]);
	endtask

	task automatic add_answer_token(ref octet_q_t q);
		case ($urandom_range(7))
			0: add_text(q, "\\r");
			1: add_text(q, "\\n");
			2: begin
				append_byte(q, CH_BS);
				case ($urandom_range(2))
					0:       append_byte(q, CH_LT);
					1:       append_byte(q, CH_QUOTE);
					default: append_byte(q, CH_BS);
				endcase
			end
			3: begin
				append_byte(q, CH_BS);
				append_byte(q, text_byte());
			end
			4:       append_byte(q, CH_CR);
			5:       append_byte(q, CH_BS);
			6:       append_byte(q, CH_LA + 8'($urandom_range(25)));
			default: append_byte(q, text_byte());
		endcase
	endtask

	// Mostly well-formed lines with random content, the rest empty lines, comments, noise and broken lines.
	task automatic build_line(ref octet_q_t q, output bit counted_line);
		int sel;
		q.delete();
		counted_line = 1'b1;
		sel = $urandom_range(99);
		if (sel < 10) begin
			counted_line = 1'b0;
			if ($urandom_range(1)) begin
				append_byte(q, CH_HASH);
				repeat ($urandom_range(4))
					append_byte(q, text_byte());
			end
		end else if (sel < 40) begin
			case ($urandom_range(3))
				0: begin
					repeat ($urandom_range(1, 5))
						append_byte(q, text_byte());
				end
				1: begin
					append_byte(q, $urandom_range(1) ? CH_UA : CH_LA);
					append_byte(q, text_byte());
				end
				2: begin
					add_text(q, $urandom_range(1) ? "AT" : "at");
					repeat ($urandom_range(4))
						append_byte(q, request_char());
				end
				default: begin
					add_text(q, $urandom_range(1) ? "AT" : "at");
					add_text(q, "\\r=");
				end
			endcase
		end else begin
			add_text(q, $urandom_range(1) ? "AT" : "at");
			repeat ($urandom_range(4))
				append_byte(q, request_char());
			add_text(q, "\\r=");
			if ($urandom_range(3) == 0)
				add_text(q, "\\r\\n");
			repeat ($urandom_range(1, 4))
				add_answer_token(q);
			if ($urandom_range(3) == 0)
				add_text(q, "\\r\\n");
		end
		if ($urandom_range(2) == 0)
			append_byte(q, CH_CR);
		append_byte(q, CH_LF);
	endtask

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Receiver: random stalls, and one long hold-off that lets the block fill up.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end
			out_ch.ready <= ($urandom_range(99) >= sink_stall);
		end
	end

	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_at_response_line_parser_unit: errors");
		$finish;
	end

	initial begin
		octet_q_t line;
		bit       counted_line;
		bit       pressed;
		int       counted;
		int       target;

		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		arst_n = 1'b0;
		send_idle = 0;
		sink_stall = 0;
		long_hold = 1'b0;
		pressed = 1'b0;
		counted = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty line, comment, one-byte line, held CR before an ordinary byte.
		send_byte(CH_LF);
		send_byte(CH_HASH);
		send_byte(8'hFF);
		send_byte(CH_LF);
		send_byte(8'h00);
		send_byte(CH_LF);
		send_text("AT");
		send_byte(CH_CR);
		send_byte("x");
		send_byte(CH_CR);
		send_byte(CH_LF);
		// Quoted blank, marker, unknown escape and a trailing backslash.
		send_text("at\"b \"\\r=\\q\\");
		send_byte(CH_LF);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle = 0;  sink_stall = 0;  end
				1: begin send_idle = 75; sink_stall = 0;  end
				2: begin send_idle = 0;  sink_stall = 75; end
				default: begin send_idle = 18; sink_stall = 18; end
			endcase
			target = counted + PHASE_ITEMS;
			while (counted < target) begin
				build_line(line, counted_line);
				if (!pressed) begin
					long_hold = 1'b1;
					pressed = 1'b1;
				end
				foreach (line[i])
					send_byte(line[i]);
				if (counted_line)
					counted += line.size();
			end
			// Sender pauses until every result of the phase has been transferred.
			in_ch.valid <= 1'b0;
			@(posedge clk);
			while (open_results != 0)
				@(posedge clk);
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && open_results == 0)
			$display("tb_at_response_line_parser_unit: clean");
		else
			$display("tb_at_response_line_parser_unit: errors");
		$finish;
	end

endmodule

[sim.f]
rtl/atrlp_pkg.sv
rtl/atrlp_in_if.sv
rtl/atrlp_out_if.sv
rtl/atrlp_core.sv
rtl/atrlp_outq.sv
rtl/at_response_line_parser_unit.sv
dv/atrlp_checker.sv
dv/tb_at_response_line_parser_unit.sv
